@@ rtl/core/gbcd_pkg.sv @@
package gbcd_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 64;
  localparam int CAPACITY    = MAX_ROWS * MAX_COLUMNS;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int CELL_W      = $clog2(CAPACITY);
  localparam int CNT_W       = CELL_W + 1;
  localparam int DIST_W      = 12;
  localparam int SIZE_W      = 7;
  localparam int HEIGHT_W    = 8;
  localparam int CELL_DATA_W = HEIGHT_W + 1;
  localparam int QUEUE_W     = DIST_W + ROW_W + COL_W;
  localparam int BEST_W      = DIST_W + 1;

  localparam logic [HEIGHT_W-1:0] HEIGHT_START = 8'h53;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LOW   = 8'h61;
  localparam logic [HEIGHT_W-1:0] HEIGHT_GOAL  = 8'h7A;
  localparam logic [BEST_W-1:0]   NONE_FOUND   = '1;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLEAR, ST_SEED, ST_SEED_W, ST_POP,
    ST_FETCH, ST_HERE, ST_NBR, ST_CHECK, ST_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              reachable;
    logic [DIST_W-1:0] distance;
  } result_t;

  function automatic logic signed [1:0] step_row(input logic [2:0] d);
    case (d)
      3'd0, 3'd1, 3'd2: step_row = -2'sd1;
      3'd3, 3'd4:       step_row = 2'sd0;
      default:          step_row = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] step_col(input logic [2:0] d);
    case (d)
      3'd0, 3'd3, 3'd5: step_col = -2'sd1;
      3'd1, 3'd6:       step_col = 2'sd0;
      default:          step_col = 2'sd1;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    if (v == '0) clamp_size = SIZE_W'(1);
    else if (v > lim) clamp_size = lim;
    else clamp_size = v;
  endfunction

  function automatic logic [HEIGHT_W:0] climb(input logic [HEIGHT_W-1:0] h);
    climb = (h == HEIGHT_START) ? {1'b0, HEIGHT_LOW} : {1'b0, h};
  endfunction

endpackage

@@ rtl/core/gbcd_ram.sv @@
module gbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/gbcd_search.sv @@
module gbcd_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [gbcd_pkg::SIZE_W-1:0]      row_count,
  input  logic [gbcd_pkg::SIZE_W-1:0]      column_count,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [gbcd_pkg::HEIGHT_W-1:0]    in_height,
  input  logic                             in_last,
  output gbcd_pkg::result_t                res,
  input  logic                             res_take
);

  localparam int RW = gbcd_pkg::ROW_W + 2;
  localparam int CW = gbcd_pkg::COL_W + 2;

  gbcd_pkg::state_t state, state_next;

  logic [gbcd_pkg::CNT_W-1:0]    load_pos, load_pos_next;
  logic [gbcd_pkg::CNT_W-1:0]    clr_cnt, clr_cnt_next;
  logic                          clr_pend, clr_pend_next;
  logic [gbcd_pkg::CELL_W-1:0]   clr_addr, clr_addr_next;
  logic [gbcd_pkg::CNT_W-1:0]    head, head_next, tail, tail_next;
  logic [gbcd_pkg::BEST_W-1:0]   best, best_next;
  logic [gbcd_pkg::ROW_W-1:0]    here_r, here_r_next, nbr_r, nbr_r_next;
  logic [gbcd_pkg::COL_W-1:0]    here_c, here_c_next, nbr_c, nbr_c_next;
  logic [gbcd_pkg::DIST_W-1:0]   here_d, here_d_next;
  logic [gbcd_pkg::HEIGHT_W:0]   here_h, here_h_next;
  logic [2:0]                    dir, dir_next;
  logic [gbcd_pkg::CELL_W-1:0]   nbr_idx, nbr_idx_next;

  logic [gbcd_pkg::SIZE_W-1:0]   rows, cols;
  logic [gbcd_pkg::CNT_W-1:0]    total;

  logic                              c_we;
  logic [gbcd_pkg::CELL_W-1:0]       c_waddr, c_raddr;
  logic [gbcd_pkg::CELL_DATA_W-1:0]  c_wdata, c_rdata;
  logic                              q_we;
  logic [gbcd_pkg::CELL_W-1:0]       q_waddr, q_raddr;
  logic [gbcd_pkg::QUEUE_W-1:0]      q_wdata, q_rdata;

  logic signed [1:0]             step_r, step_c;
  logic signed [RW-1:0]          nr;
  logic signed [CW-1:0]          nc;
  logic                          in_grid;
  logic [gbcd_pkg::DIST_W-1:0]   d_plus;

  function automatic logic [gbcd_pkg::CELL_W-1:0] cell_index(
      input logic [gbcd_pkg::ROW_W-1:0]  r,
      input logic [gbcd_pkg::COL_W-1:0]  c,
      input logic [gbcd_pkg::SIZE_W-1:0] nc_cols);
    logic [gbcd_pkg::ROW_W+gbcd_pkg::SIZE_W:0] p;
    p = (gbcd_pkg::ROW_W+gbcd_pkg::SIZE_W+1)'(r) * (gbcd_pkg::ROW_W+gbcd_pkg::SIZE_W+1)'(nc_cols)
        + (gbcd_pkg::ROW_W+gbcd_pkg::SIZE_W+1)'(c);
    cell_index = p[gbcd_pkg::CELL_W-1:0];
  endfunction

  // heights with visited flag on top
  gbcd_ram #(.WIDTH(gbcd_pkg::CELL_DATA_W), .DEPTH(gbcd_pkg::CAPACITY)) u_cell_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // queue entry: {distance, row, column}
  gbcd_ram #(.WIDTH(gbcd_pkg::QUEUE_W), .DEPTH(gbcd_pkg::CAPACITY)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign rows  = gbcd_pkg::clamp_size(row_count, gbcd_pkg::SIZE_W'(gbcd_pkg::MAX_ROWS));
  assign cols  = gbcd_pkg::clamp_size(column_count, gbcd_pkg::SIZE_W'(gbcd_pkg::MAX_COLUMNS));
  assign total = gbcd_pkg::CNT_W'(rows * cols);

  assign step_r = gbcd_pkg::step_row(dir);
  assign step_c = gbcd_pkg::step_col(dir);

  assign nr = $signed({2'b00, here_r}) + {{(RW-2){step_r[1]}}, step_r};
  assign nc = $signed({2'b00, here_c}) + {{(CW-2){step_c[1]}}, step_c};
  assign in_grid = !nr[RW-1] && !nc[CW-1] &&
                   (RW'(unsigned'(nr)) < RW'(rows)) && (CW'(unsigned'(nc)) < CW'(cols));
  assign d_plus = here_d + gbcd_pkg::DIST_W'(1);

  always_comb begin
    state_next    = state;
    load_pos_next = load_pos;
    clr_cnt_next  = clr_cnt;
    clr_pend_next = 1'b0;
    clr_addr_next = clr_addr;
    head_next     = head;
    tail_next     = tail;
    best_next     = best;
    here_r_next   = here_r;
    here_c_next   = here_c;
    here_d_next   = here_d;
    here_h_next   = here_h;
    dir_next      = dir;
    nbr_r_next    = nbr_r;
    nbr_c_next    = nbr_c;
    nbr_idx_next  = nbr_idx;
    in_ready      = 1'b0;
    c_we          = 1'b0;
    c_waddr       = load_pos[gbcd_pkg::CELL_W-1:0];
    c_wdata       = {1'b0, in_height};
    c_raddr       = '0;
    q_we          = 1'b0;
    q_waddr       = tail[gbcd_pkg::CELL_W-1:0];
    q_wdata       = {d_plus, nbr_r, nbr_c};
    q_raddr       = head[gbcd_pkg::CELL_W-1:0];
    res.valid     = 1'b0;
    res.reachable = (best != gbcd_pkg::NONE_FOUND);
    res.distance  = (best != gbcd_pkg::NONE_FOUND) ? best[gbcd_pkg::DIST_W-1:0] : '0;

    case (state)
      gbcd_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (load_pos < total) begin
            c_we          = 1'b1;
            load_pos_next = load_pos + gbcd_pkg::CNT_W'(1);
          end
          if (in_last) begin
            clr_cnt_next = '0;
            state_next   = gbcd_pkg::ST_CLEAR;
          end
        end
      end
      gbcd_pkg::ST_CLEAR: begin
        // read one cell, write it back with the visited flag dropped
        c_raddr = clr_cnt[gbcd_pkg::CELL_W-1:0];
        c_waddr = clr_addr;
        c_wdata = {1'b0, c_rdata[gbcd_pkg::HEIGHT_W-1:0]};
        c_we    = clr_pend;
        if (clr_cnt < total) begin
          clr_pend_next = 1'b1;
          clr_addr_next = clr_cnt[gbcd_pkg::CELL_W-1:0];
          clr_cnt_next  = clr_cnt + gbcd_pkg::CNT_W'(1);
        end else if (!clr_pend) begin
          state_next = gbcd_pkg::ST_SEED;
        end
      end
      gbcd_pkg::ST_SEED: begin
        state_next = gbcd_pkg::ST_SEED_W;
      end
      gbcd_pkg::ST_SEED_W: begin
        c_we      = 1'b1;
        c_waddr   = '0;
        c_wdata   = {1'b1, c_rdata[gbcd_pkg::HEIGHT_W-1:0]};
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = '0;
        head_next = '0;
        tail_next = gbcd_pkg::CNT_W'(1);
        best_next = (c_rdata[gbcd_pkg::HEIGHT_W-1:0] == gbcd_pkg::HEIGHT_GOAL) ?
                    '0 : gbcd_pkg::NONE_FOUND;
        state_next = gbcd_pkg::ST_POP;
      end
      gbcd_pkg::ST_POP: begin
        if (head == tail) begin
          state_next = gbcd_pkg::ST_DONE;
        end else begin
          head_next  = head + gbcd_pkg::CNT_W'(1);
          state_next = gbcd_pkg::ST_FETCH;
        end
      end
      gbcd_pkg::ST_FETCH: begin
        here_d_next = q_rdata[gbcd_pkg::QUEUE_W-1 -: gbcd_pkg::DIST_W];
        here_r_next = q_rdata[gbcd_pkg::COL_W +: gbcd_pkg::ROW_W];
        here_c_next = q_rdata[gbcd_pkg::COL_W-1:0];
        c_raddr     = cell_index(q_rdata[gbcd_pkg::COL_W +: gbcd_pkg::ROW_W],
                                 q_rdata[gbcd_pkg::COL_W-1:0], cols);
        state_next  = gbcd_pkg::ST_HERE;
      end
      gbcd_pkg::ST_HERE: begin
        here_h_next = gbcd_pkg::climb(c_rdata[gbcd_pkg::HEIGHT_W-1:0]);
        dir_next    = '0;
        state_next  = gbcd_pkg::ST_NBR;
      end
      gbcd_pkg::ST_NBR: begin
        nbr_r_next   = nr[gbcd_pkg::ROW_W-1:0];
        nbr_c_next   = nc[gbcd_pkg::COL_W-1:0];
        nbr_idx_next = cell_index(nr[gbcd_pkg::ROW_W-1:0], nc[gbcd_pkg::COL_W-1:0], cols);
        c_raddr      = nbr_idx_next;
        if (in_grid) begin
          state_next = gbcd_pkg::ST_CHECK;
        end else if (dir == 3'd7) begin
          state_next = gbcd_pkg::ST_POP;
        end else begin
          dir_next = dir + 3'd1;
        end
      end
      gbcd_pkg::ST_CHECK: begin
        if (!c_rdata[gbcd_pkg::HEIGHT_W] &&
            gbcd_pkg::climb(c_rdata[gbcd_pkg::HEIGHT_W-1:0]) <= here_h + 9'd1) begin
          c_we      = 1'b1;
          c_waddr   = nbr_idx;
          c_wdata   = {1'b1, c_rdata[gbcd_pkg::HEIGHT_W-1:0]};
          q_we      = 1'b1;
          tail_next = tail + gbcd_pkg::CNT_W'(1);
          if (c_rdata[gbcd_pkg::HEIGHT_W-1:0] == gbcd_pkg::HEIGHT_GOAL &&
              {1'b0, d_plus} < best)
            best_next = {1'b0, d_plus};
        end
        if (dir == 3'd7) begin
          state_next = gbcd_pkg::ST_POP;
        end else begin
          dir_next   = dir + 3'd1;
          state_next = gbcd_pkg::ST_NBR;
        end
      end
      gbcd_pkg::ST_DONE: begin
        res.valid = 1'b1;
        if (res_take) begin
          load_pos_next = '0;
          state_next    = gbcd_pkg::ST_LOAD;
        end
      end
      default: state_next = gbcd_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gbcd_pkg::ST_LOAD;
      load_pos <= '0;
      clr_cnt  <= '0;
      clr_pend <= 1'b0;
      head     <= '0;
      tail     <= '0;
      best     <= gbcd_pkg::NONE_FOUND;
      dir      <= '0;
    end else begin
      state    <= state_next;
      load_pos <= load_pos_next;
      clr_cnt  <= clr_cnt_next;
      clr_pend <= clr_pend_next;
      head     <= head_next;
      tail     <= tail_next;
      best     <= best_next;
      dir      <= dir_next;
    end
  end

  always_ff @(posedge clk) begin
    clr_addr <= clr_addr_next;
    here_r   <= here_r_next;
    here_c   <= here_c_next;
    here_d   <= here_d_next;
    here_h   <= here_h_next;
    nbr_r    <= nbr_r_next;
    nbr_c    <= nbr_c_next;
    nbr_idx  <= nbr_idx_next;
  end

endmodule

@@ rtl/core/grid_bfs_climb_distance_unit.sv @@
// Channel   | Direction | Handshake              | Payload
// s_axis    | in        | s_axis_tvalid/tready   | tdata[7:0] cell_height, tlast last_cell
// m_axis    | out       | m_axis_tvalid/tready   | tdata[11:0] shortest_distance, tuser reachable
// apb       | in        | psel/penable, pready=1 | reg 0 row_count @0, reg 1 column_count @4
//
// Cells load one per cycle while the unit is in its load state. The last cell starts a
// visited-flag clearing pass over rows*columns cells, a start-cell seed, then the search: pop,
// fetch and here per dequeued cell, a cell-memory read per neighbor, a check if it is in the grid.
// Synchronous active-high reset; no memory clearing at reset.
// A finished result sits in the output register; the next grid loads while it waits.
module grid_bfs_climb_distance_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cell_height
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] shortest_distance, [15:12] zero
  output logic        m_axis_tuser,   // [0] reachable
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [gbcd_pkg::SIZE_W-1:0] row_count, column_count;
  gbcd_pkg::result_t           res;
  logic                        res_take;
  logic                        cfg_write;
  logic [gbcd_pkg::DIST_W-1:0] out_distance;
  logic                        out_reachable;

  // APB: register index is paddr[2]; write on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= gbcd_pkg::SIZE_W'(64);
      column_count <= gbcd_pkg::SIZE_W'(64);
    end else if (cfg_write) begin
      if (paddr[2] == gbcd_pkg::REG_ROW_COUNT) row_count <= pwdata[gbcd_pkg::SIZE_W-1:0];
      else column_count <= pwdata[gbcd_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == gbcd_pkg::REG_ROW_COUNT) prdata = 32'(row_count);
      else prdata = 32'(column_count);
    end
  end

  gbcd_search u_search (
    .clk(clk), .rst(rst),
    .row_count(row_count), .column_count(column_count),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_height(s_axis_tdata), .in_last(s_axis_tlast),
    .res(res), .res_take(res_take)
  );

  // take the search result when the output register is free or draining
  assign res_take = res.valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_distance  <= res.distance;
      out_reachable <= res.reachable;
    end
  end

  assign m_axis_tdata = {4'b0000, out_distance};
  assign m_axis_tuser = out_reachable;

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("unreachable result carries nonzero distance");

  a_rise_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(res.valid))
    else $error("output valid without a finished search");

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still taken after the last cell");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

@@ sim/tb_grid_bfs_climb_distance_unit.sv @@
`timescale 1ns / 1ps

module tb_grid_bfs_climb_distance_unit;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct {
    logic [gbcd_pkg::DIST_W-1:0] distance;
    logic                        reachable;
  } climb_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] cell_height
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [11:0] shortest_distance, [15:12] zero
  logic        m_axis_tuser;   // [0] reachable
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grid_bfs_climb_distance_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Own copy of the block state used for prediction.
  logic [gbcd_pkg::SIZE_W-1:0]   row_reg;
  logic [gbcd_pkg::SIZE_W-1:0]   col_reg;
  logic [gbcd_pkg::HEIGHT_W-1:0] grid_height [gbcd_pkg::CAPACITY];
  bit                            seen        [gbcd_pkg::CAPACITY];
  int                            hop_count   [gbcd_pkg::CAPACITY];
  int                            frontier    [gbcd_pkg::CAPACITY];
  int                            fill_pos;

  climb_result_t pending_results[$];
  int            mismatches;
  int            cycle_count;
  int            last_accept_cycle;
  int            burst_left;
  int            cells_sent;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count - last_accept_cycle > WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int size_of(input logic [gbcd_pkg::SIZE_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic int climb_level(input logic [gbcd_pkg::HEIGHT_W-1:0] h);
    return (h == gbcd_pkg::HEIGHT_START) ? int'(gbcd_pkg::HEIGHT_LOW) : int'(h);
  endfunction

  // Breadth-first search from (0,0); returns the shortest hop count to a goal cell.
  function automatic climb_result_t search_grid(input int rows, input int cols);
    climb_result_t res;
    int head, tail, here, r, c, nr, nc, n, lvl, best;
    for (int i = 0; i < gbcd_pkg::CAPACITY; i++) seen[i] = 0;
    head = 0;
    tail = 0;
    seen[0] = 1;
    hop_count[0] = 0;
    frontier[tail++] = 0;
    while (head < tail) begin
      here = frontier[head++];
      r = here / cols;
      c = here % cols;
      lvl = climb_level(grid_height[here]);
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nr = r + dr;
          nc = c + dc;
          if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= rows || nc >= cols)
            continue;
          n = nr * cols + nc;
          if (seen[n] || climb_level(grid_height[n]) > lvl + 1) continue;
          seen[n] = 1;
          hop_count[n] = hop_count[here] + 1;
          frontier[tail++] = n;
        end
      end
    end
    best = -1;
    for (int i = 0; i < rows * cols; i++)
      if (seen[i] && grid_height[i] == gbcd_pkg::HEIGHT_GOAL &&
          (best < 0 || hop_count[i] < best))
        best = hop_count[i];
    res.reachable = (best >= 0);
    res.distance  = (best >= 0) ? gbcd_pkg::DIST_W'(best) : '0;
    return res;
  endfunction

  // Apply one accepted cell request to the predicted state.
  task automatic absorb_cell(input logic [7:0] h, input logic last);
    int rows, cols;
    rows = size_of(row_reg, gbcd_pkg::MAX_ROWS);
    cols = size_of(col_reg, gbcd_pkg::MAX_COLUMNS);
    if (fill_pos < rows * cols) begin
      grid_height[fill_pos] = h;
      fill_pos++;
    end
    if (last) begin
      pending_results.push_back(search_grid(rows, cols));
      fill_pos = 0;
    end
  endtask

  // Send one cell request; bursts with random gaps in between.
  task automatic send_cell(input logic [7:0] h, input logic last);
    int  gap;
    logic ok;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = h;
    s_axis_tlast  = last;
    // tready is stable from just after the falling edge up to the rising edge
    forever begin
      #1 ok = s_axis_tready;
      @(posedge clk);
      if (ok) break;
      @(negedge clk);
    end
    last_accept_cycle = cycle_count;
    cells_sent++;
    absorb_cell(h, last);
  endtask

  // Hold off until every expected result is back, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == gbcd_pkg::REG_ROW_COUNT) row_reg = val[gbcd_pkg::SIZE_W-1:0];
    else col_reg = val[gbcd_pkg::SIZE_W-1:0];
  endtask

  task automatic set_size(input logic [31:0] rows, input logic [31:0] cols);
    wait_drained();
    write_reg(gbcd_pkg::REG_ROW_COUNT, rows);
    write_reg(gbcd_pkg::REG_COLUMN_COUNT, cols);
  endtask

  // Height of one cell in a given style: 0 gentle ramp, 1 letters, 2 any byte.
  function automatic logic [7:0] pick_height(input int style, input int r, input int c);
    int v;
    case (style)
      0: begin
        v = r + c + $urandom_range(0, 2);
        if (v > 25) v = 25;
        return 8'(int'(gbcd_pkg::HEIGHT_LOW) + v);
      end
      1: begin
        if ($urandom_range(0, 9) == 0) return gbcd_pkg::HEIGHT_START;
        return 8'(int'(gbcd_pkg::HEIGHT_LOW) + $urandom_range(0, 25));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send a grid at the current size: count cells, last marked on the final one.
  task automatic send_grid(input int count, input int style);
    int cols;
    cols = size_of(col_reg, gbcd_pkg::MAX_COLUMNS);
    for (int i = 0; i < count; i++)
      send_cell(pick_height(style, i / cols, i % cols), i == count - 1);
  endtask

  task automatic test_full_default_grid();
    // fills every cell that any later grid reaches, so early grids never read stale memory
    set_size(8, 64);
    for (int i = 0; i < 512; i++)
      send_cell((i == 511) ? gbcd_pkg::HEIGHT_GOAL : gbcd_pkg::HEIGHT_LOW, i == 511);
    wait_drained();
  endtask

  task automatic test_size_extremes();
    set_size(0, 0);                           // zero acts as one
    send_cell(gbcd_pkg::HEIGHT_GOAL, 1'b1);   // start cell is the goal
    send_cell(gbcd_pkg::HEIGHT_START, 1'b1);  // start only, nothing found
    set_size(127, 1);                         // clamps to 64 rows
    send_grid(64, 0);
    set_size(1, 64);
    send_grid(64, 0);
    set_size(2, 2);
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(gbcd_pkg::HEIGHT_GOAL, 1'b0);
    send_cell(gbcd_pkg::HEIGHT_GOAL, 1'b1);
  endtask

  task automatic test_load_edges();
    set_size(3, 3);
    // too many cells: extras ignored until the last one
    for (int i = 0; i < 11; i++) send_cell(gbcd_pkg::HEIGHT_GOAL - 8'(i % 2), i == 10);
    // early last cell: the rest keeps earlier contents
    send_cell(gbcd_pkg::HEIGHT_LOW, 1'b0);
    send_cell(gbcd_pkg::HEIGHT_START, 1'b0);
    send_cell(8'hAA, 1'b1);
    set_size(8, 64);
    send_cell(gbcd_pkg::HEIGHT_START, 1'b1);
  endtask

  task automatic test_random_grids();
    int rows, cols, total, count, style, pick;
    while (cells_sent < 1850) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) set_size(0, $urandom_range(1, 8));
        else if (pick == 1) set_size($urandom_range(1, 8), 127);
        else if (pick == 2) set_size($urandom_range(10, 20), $urandom_range(10, 20));
        else set_size($urandom_range(1, 8), $urandom_range(1, 8));
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
      rows  = size_of(row_reg, gbcd_pkg::MAX_ROWS);
      cols  = size_of(col_reg, gbcd_pkg::MAX_COLUMNS);
      total = rows * cols;
      style = ($urandom_range(0, 9) < 5) ? 0 : $urandom_range(1, 2);
      pick  = $urandom_range(0, 9);
      if (pick == 0) count = $urandom_range(1, total);
      else if (pick == 1) count = total + $urandom_range(1, 3);
      else count = total;
      send_grid(count, style);
    end
  endtask

  // Receiver: stall pattern of its own, check each result against the oldest expectation.
  initial begin
    climb_result_t want;
    logic          got_valid;
    logic [15:0]   got_data;
    logic          got_user;
    int            mode;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (cycle_count % 300 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = $urandom_range(0, 1);
        default: m_axis_tready = (cycle_count % 7) < 3;
      endcase
      #1;
      got_valid = m_axis_tvalid;
      got_data  = m_axis_tdata;
      got_user  = m_axis_tuser;
      @(posedge clk);
      if (got_valid && m_axis_tready) begin
        last_accept_cycle = cycle_count;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual dist=%0d reach=%0b",
                   $time, got_data[11:0], got_user);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got_data[11:0] !== want.distance) begin
            $display("%0t distance: expected %0d, actual %0d", $time, want.distance,
                     got_data[11:0]);
            mismatches++;
          end
          if (got_user !== want.reachable) begin
            $display("%0t reachable: expected %0b, actual %0b", $time, want.reachable,
                     got_user);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycle_count = 0;
    last_accept_cycle = 0;
    burst_left = 0;
    cells_sent = 0;
    fill_pos = 0;
    row_reg = gbcd_pkg::SIZE_W'(64);
    col_reg = gbcd_pkg::SIZE_W'(64);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_full_default_grid();
    test_size_extremes();
    test_load_edges();
    test_random_grids();
    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
